@@ rtl/core/lss_pkg.sv @@
// Shared types, constants and register indexes for the lidar scan segmenter.
// No dependencies; every other file of the block imports this package.
package lss_pkg;

    // Payload widths fixed by the stream format
    localparam int RANGE_W    = 24;
    localparam int OUT_IDX_W  = 12;
    localparam int END_W      = 13;
    localparam int SIZE_W     = 13;
    localparam int DISC_W     = 16;
    localparam int BF_W       = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [RANGE_W-1:0] NONFINITE = '1;

    localparam int LSS_MAX_RAYS = 4096;

    // Output queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Register reset values
    localparam logic [RANGE_W-1:0] RST_RANGE_MIN = 24'd0;
    localparam logic [RANGE_W-1:0] RST_RANGE_MAX = 24'd16777214;
    localparam logic [DISC_W-1:0]  RST_DISCOUNT  = 16'd58982;
    localparam logic [BF_W-1:0]    RST_BREAK_FAC = 16'd768;
    localparam logic [SIZE_W-1:0]  RST_MIN_SIZE  = 13'd5;
    localparam logic               RST_PART_EN   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN  = 3'd0,
        CFG_RANGE_MAX  = 3'd1,
        CFG_DISCOUNT   = 3'd2,
        CFG_BREAK_FAC  = 3'd3,
        CFG_MIN_SIZE   = 3'd4,
        CFG_PART_EN    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_min;
        logic [RANGE_W-1:0] range_max;
        logic [DISC_W-1:0]  discount;
        logic [BF_W-1:0]    break_factor;
        logic [SIZE_W-1:0]  min_size;
        logic               part_en;
    } lss_cfg_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]    ray_index;
        logic                    ray_hit;
        logic                    ray_continuous;
        logic                    partition_found;
        logic [OUT_IDX_W-1:0]    partition_begin;
        logic signed [END_W-1:0] partition_end;
        logic [RANGE_W-1:0]      max_hit_range;
        logic                    final_result;
    } lss_result_t;

    // One or two results handed to the output queue in a cycle
    typedef struct packed {
        logic [1:0]  count;
        lss_result_t res0;
        lss_result_t res1;
    } lss_push_t;

endpackage

@@ rtl/core/lss_cfg_regs.sv @@
// Configuration register file of the lidar scan segmenter.
// Depends on lss_pkg for the register indexes, widths and reset values.
module lss_cfg_regs
    import lss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output lss_cfg_t              cfg
);

    lss_cfg_t cfg_reg;
    lss_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RANGE_MIN: cfg_next.range_min    = cfg_data[RANGE_W-1:0];
                CFG_RANGE_MAX: cfg_next.range_max    = cfg_data[RANGE_W-1:0];
                CFG_DISCOUNT:  cfg_next.discount     = cfg_data[DISC_W-1:0];
                CFG_BREAK_FAC: cfg_next.break_factor = cfg_data[BF_W-1:0];
                CFG_MIN_SIZE:  cfg_next.min_size     = cfg_data[SIZE_W-1:0];
                CFG_PART_EN:   cfg_next.part_en      = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min    <= RST_RANGE_MIN;
            cfg_reg.range_max    <= RST_RANGE_MAX;
            cfg_reg.discount     <= RST_DISCOUNT;
            cfg_reg.break_factor <= RST_BREAK_FAC;
            cfg_reg.min_size     <= RST_MIN_SIZE;
            cfg_reg.part_en      <= RST_PART_EN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/lss_seg_core.sv @@
// Per-ray datapath: input register, scan state and the combinational decision logic.
// Depends on lss_pkg for the config and result structs.
module lss_seg_core
    import lss_pkg::*;
#(
    parameter int MAX_RAYS = LSS_MAX_RAYS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lss_cfg_t           cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [RANGE_W-1:0] ray_range,
    input  logic               last_ray,
    input  logic               room,
    output lss_push_t          push
);

    localparam int IDX_W = $clog2(MAX_RAYS);
    localparam int PS_W  = IDX_W + 1;
    localparam int CMP_W = (PS_W > SIZE_W) ? PS_W : SIZE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RAYS - 1);

    // Input register
    logic               in_valid_reg;
    logic [RANGE_W-1:0] in_range_reg;
    logic               in_last_reg;

    // Scan state
    logic [IDX_W-1:0]   cnt_reg;
    logic [RANGE_W-1:0] prev_range_reg;
    logic               prev_hit_reg;
    logic               prev_cont_reg;
    logic [RANGE_W-1:0] mean_reg;
    logic [PS_W-1:0]    pstart_reg;
    logic [RANGE_W-1:0] best_reg;

    logic               fire;
    logic               accept;
    logic               is_last;
    logic               first_ray;
    logic               hit;
    logic [RANGE_W-1:0] best_upd;
    logic [RANGE_W-1:0] step;
    logic [39:0]        bf_mean;
    logic [39:0]        step_ext;
    logic               brk;
    logic               upd_en;
    logic [RANGE_W-1:0] mean_eff;
    logic signed [RANGE_W:0] delta;
    logic [DISC_W:0]    wgt;
    logic signed [42:0] prod;
    logic signed [42:0] rnd;
    logic [RANGE_W-1:0] mean_calc;
    logic               cont_prev;
    logic [IDX_W-1:0]   ka;
    logic [PS_W-1:0]    m_a;
    logic               close_a;
    logic               found_a;
    logic [PS_W-1:0]    ps_a;
    logic [PS_W-1:0]    m_b;
    logic               found_b;
    lss_result_t        res_a;
    lss_result_t        res_b;

    function automatic lss_result_t make_result(
        input logic [IDX_W-1:0]   k,
        input logic               k_hit,
        input logic               k_cont,
        input logic               found,
        input logic [PS_W-1:0]    ps,
        input logic               fin,
        input logic [RANGE_W-1:0] best
    );
        lss_result_t res;
        logic signed [IDX_W+1:0] k_s;
        logic signed [IDX_W+1:0] end_s;
        k_s   = $signed({2'b00, k});
        end_s = k_hit ? k_s : k_s - $signed((IDX_W+2)'(1));
        res.ray_index       = OUT_IDX_W'(k);
        res.ray_hit         = k_hit;
        res.ray_continuous  = k_cont;
        res.partition_found = found;
        res.partition_begin = '0;
        res.partition_end   = '0;
        if (found)
        begin
            res.partition_begin = OUT_IDX_W'(ps);
            res.partition_end   = END_W'(end_s);
        end
        res.max_hit_range   = best;
        res.final_result    = fin;
        return res;
    endfunction

    // Hold the input register until its ray has gone through the decision logic
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        first_ray = (cnt_reg == '0);
        is_last   = in_last_reg || (cnt_reg == LAST_IDX);
        hit       = (in_range_reg != '0) && (in_range_reg != NONFINITE)
                    && (in_range_reg >= cfg.range_min) && (in_range_reg <= cfg.range_max);
        best_upd  = (hit && (in_range_reg > best_reg)) ? in_range_reg : best_reg;

        // Absolute range step, saturated after a non-finite ray
        if (prev_range_reg == NONFINITE)
            step = NONFINITE;
        else if (in_range_reg >= prev_range_reg)
            step = in_range_reg - prev_range_reg;
        else
            step = prev_range_reg - in_range_reg;

        bf_mean  = 40'(cfg.break_factor) * 40'(mean_reg);
        step_ext = {8'b0, step, 8'b0};
        brk      = step_ext > bf_mean;
        upd_en   = cfg.part_en && !first_ray && hit;

        // g*m + (1-g)*d written as m + (1-g)*(d-m), rounded half up
        mean_eff  = (mean_reg == '0) ? step : mean_reg;
        delta     = $signed({1'b0, step}) - $signed({1'b0, mean_eff});
        wgt       = (DISC_W+1)'(1 << DISC_W) - {1'b0, cfg.discount};
        prod      = delta * $signed({1'b0, wgt});
        rnd       = prod + 43'sd32768;
        mean_calc = mean_eff + rnd[RANGE_W+15:16];

        cont_prev = prev_cont_reg && !(upd_en && brk);

        // Decision of the previous ray
        ka      = cnt_reg - IDX_W'(1);
        m_a     = {1'b0, ka} - pstart_reg + PS_W'(1);
        close_a = cfg.part_en && (!prev_hit_reg || !cont_prev);
        found_a = close_a && (CMP_W'(m_a) >= CMP_W'(cfg.min_size));
        ps_a    = (!first_ray && close_a) ? ({1'b0, ka} + PS_W'(1)) : pstart_reg;

        // Decision of the closing ray of the scan
        m_b     = {1'b0, cnt_reg} - ps_a + PS_W'(1);
        found_b = cfg.part_en && (CMP_W'(m_b) >= CMP_W'(cfg.min_size));

        res_a = make_result(ka, prev_hit_reg, cfg.part_en && cont_prev, found_a,
                            pstart_reg, 1'b0, best_upd);
        res_b = make_result(cnt_reg, hit, 1'b0, found_b, ps_a, 1'b1, best_upd);

        push.count = '0;
        push.res0  = first_ray ? res_b : res_a;
        push.res1  = res_b;
        if (fire)
            push.count = 2'({1'b0, !first_ray} + {1'b0, is_last});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_range_reg <= ray_range;
            in_last_reg  <= last_ray;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            prev_range_reg <= '0;
            prev_hit_reg   <= 1'b0;
            prev_cont_reg  <= 1'b0;
            mean_reg       <= '0;
            pstart_reg     <= '0;
            best_reg       <= '0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                cnt_reg        <= '0;
                prev_range_reg <= '0;
                prev_hit_reg   <= 1'b0;
                prev_cont_reg  <= 1'b0;
                mean_reg       <= '0;
                pstart_reg     <= '0;
                best_reg       <= '0;
            end
            else
            begin
                cnt_reg        <= cnt_reg + IDX_W'(1);
                prev_range_reg <= in_range_reg;
                prev_hit_reg   <= hit;
                prev_cont_reg  <= !first_ray;
                pstart_reg     <= ps_a;
                best_reg       <= best_upd;
                if (upd_en)
                    mean_reg <= mean_calc;
            end
        end
    end

endmodule

@@ rtl/core/lss_out_queue.sv @@
// Four-entry result queue between the decision logic and the output stream.
// Depends on lss_pkg for the result and push structs.
module lss_out_queue
    import lss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lss_push_t   push,
    output logic        room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output lss_result_t head
);

    lss_result_t       q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              pop;

    // Room for a full pair of results
    assign room     = count_reg <= (QPTR_W+1)'(QDEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign head     = q_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            q_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/lidar_scan_segmenter.sv @@
// Top level of the lidar scan segmenter: config registers, decision core, result queue.
// Depends on lss_pkg, lss_cfg_regs, lss_seg_core and lss_out_queue.
//
//   channel   group                          moves                        width
//   -------   ----------------------------   --------------------------   -----
//   input     s_tvalid/s_tready/s_tdata      one ray request              24+1
//             s_tlast
//   output    m_tvalid/m_tready/m_tdata      one ray decision             64+1+1
//             m_tuser/m_tlast
//   config    cfg_valid/cfg_ready            one register write request   3+24
//             cfg_index/cfg_data
//
// One ray request is taken every cycle while the queue has room for two results. A ray waits
// in the input register; the decision logic (one range-step multiply and one mean-update
// multiply) writes its results into a four-entry queue whose count register drives m_tvalid.
// The last ray of a scan yields two results unless it is also the first; the queue drains
// one per cycle while m_tready is high. s_tready drops only while it holds three or more.
// Reset clears all scan state and loads the register defaults; no clearing pass is needed.
module lidar_scan_segmenter
    import lss_pkg::*;
#(
    parameter int MAX_RAYS = LSS_MAX_RAYS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // ray request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [23:0] ray_range
    input  logic                  s_tlast,    // last_ray
    // ray decision
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,    // [11:0] ray_index, [12] ray_hit,
                                              // [13] ray_continuous, [25:14] partition_begin,
                                              // [38:26] partition_end, [62:39] max_hit_range,
                                              // [63] zero
    output logic                  m_tuser,    // partition_found
    output logic                  m_tlast,    // final_result
    // register write request
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lss_cfg_t    cfg;
    lss_push_t   push;
    lss_result_t head;
    logic        room;

    lss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance a ray per cycle while the queue has room for a pair of results
    lss_seg_core #(
        .MAX_RAYS (MAX_RAYS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .ray_range (s_tdata[RANGE_W-1:0]),
        .last_ray  (s_tlast),
        .room      (room),
        .push      (push)
    );

    lss_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the head result, first field in the lowest bits
    assign m_tdata = {1'b0, head.max_hit_range, head.partition_end, head.partition_begin,
                      head.ray_continuous, head.ray_hit, head.ray_index};
    assign m_tuser = head.partition_found;
    assign m_tlast = head.final_result;

endmodule

@@ rtl/core/lss_checker.sv @@
// Port-level checker of the lidar scan segmenter, bound to the top level.
// Depends on lss_pkg for the port widths and on lidar_scan_segmenter for the bind.
module lss_checker
    import lss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // A stalled decision holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled decision changed");

    // Partition fields are zero unless a partition is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[38:14] == '0)
    else $error("partition fields set without a partition");

    // The closing ray of a scan never continues a stretch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[13])
    else $error("final decision marked continuous");

    // Ray requests are held back only while decisions wait downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind lidar_scan_segmenter lss_checker u_lss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);

@@ dv/tb_lidar_scan_segmenter.sv @@
// Self-checking testbench for lidar_scan_segmenter: ray requests in, ray decisions out,
// each checked against a cycle-free predictor kept in a small scoreboard class.
// Depends on lss_pkg and the lidar_scan_segmenter RTL.
module tb_lidar_scan_segmenter;
    import lss_pkg::*;

    // Predict the decisions of one scan and hold them until the block delivers them.
    class ray_decision_scoreboard;
        // register copy
        logic [RANGE_W-1:0] range_min;
        logic [RANGE_W-1:0] range_max;
        logic [DISC_W-1:0]  discount;
        logic [BF_W-1:0]    brk_factor;
        logic [SIZE_W-1:0]  min_size;
        logic               part_en;
        // scan state
        int                 next_ray;
        logic [RANGE_W-1:0] prev_range;
        bit                 prev_hit;
        bit                 prev_cont;
        logic [RANGE_W-1:0] step_mean;
        int                 part_start;
        logic [RANGE_W-1:0] best_hit;
        lss_result_t        decisions_q[$];
        int                 errors;

        function new();
            range_min  = RST_RANGE_MIN;
            range_max  = RST_RANGE_MAX;
            discount   = RST_DISCOUNT;
            brk_factor = RST_BREAK_FAC;
            min_size   = RST_MIN_SIZE;
            part_en    = RST_PART_EN;
            errors     = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            next_ray   = 0;
            prev_range = '0;
            prev_hit   = 1'b0;
            prev_cont  = 1'b0;
            step_mean  = '0;
            part_start = 0;
            best_hit   = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RANGE_MIN: range_min  = val;
                CFG_RANGE_MAX: range_max  = val;
                CFG_DISCOUNT:  discount   = DISC_W'(val);
                CFG_BREAK_FAC: brk_factor = BF_W'(val);
                CFG_MIN_SIZE:  min_size   = SIZE_W'(val);
                CFG_PART_EN:   part_en    = val[0];
                default: ;
            endcase
        endfunction

        // Decide ray k and close the open partition where the ray ends a stretch.
        function lss_result_t decide_ray(int k, bit hit, bit cont, bit closing);
            lss_result_t res;
            int          span;
            res = '0;
            if (part_en) begin
                span = k - part_start + 1;
                if (!hit || !cont) begin
                    if (span >= int'(min_size)) begin
                        res.partition_found = 1'b1;
                        res.partition_begin = OUT_IDX_W'(part_start);
                        res.partition_end   = hit ? END_W'(k) : END_W'(k - 1);
                    end
                    part_start = k + 1;
                end
            end
            res.ray_index      = OUT_IDX_W'(k);
            res.ray_hit        = hit;
            res.ray_continuous = part_en && cont;
            res.max_hit_range  = best_hit;
            res.final_result   = closing;
            return res;
        endfunction

        function void note_ray(logic [RANGE_W-1:0] rng, logic last_flag);
            int         idx;
            bit         closing;
            bit         hit;
            logic [63:0] step;
            logic [63:0] acc;
            idx     = next_ray;
            closing = last_flag;
            if (idx >= LSS_MAX_RAYS - 1)
                closing = 1'b1;
            hit = rng != 0 && rng != NONFINITE && rng >= range_min && rng <= range_max;
            if (hit && rng > best_hit)
                best_hit = rng;
            if (part_en && idx > 0 && hit) begin
                if (prev_range == NONFINITE)
                    step = 64'(NONFINITE);
                else if (rng >= prev_range)
                    step = 64'(rng - prev_range);
                else
                    step = 64'(prev_range - rng);
                if ((step << 8) > 64'(brk_factor) * 64'(step_mean))
                    prev_cont = 1'b0;
                if (step_mean == 0)
                    step_mean = RANGE_W'(step);
                acc = 64'(discount) * 64'(step_mean)
                    + (64'd65536 - 64'(discount)) * step + 64'd32768;
                step_mean = RANGE_W'(acc >> 16);
            end
            if (idx > 0)
                decisions_q.insert(decisions_q.size(),
                                   decide_ray(idx - 1, prev_hit, prev_cont, 1'b0));
            if (closing) begin
                decisions_q.insert(decisions_q.size(), decide_ray(idx, hit, 1'b0, 1'b1));
                clear_scan();
                return;
            end
            prev_range = rng;
            prev_hit   = hit;
            prev_cont  = (idx != 0);
            next_ray   = idx + 1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            lss_result_t want;
            if (decisions_q.size() == 0) begin
                $error("ray decision with none pending: tdata=%h tuser=%b tlast=%b",
                       tdata, tuser, tlast);
                errors++;
                return;
            end
            want = decisions_q.pop_front();
            compare_field("ray_index",       32'(want.ray_index),       32'(tdata[11:0]));
            compare_field("ray_hit",         32'(want.ray_hit),         32'(tdata[12]));
            compare_field("ray_continuous",  32'(want.ray_continuous),  32'(tdata[13]));
            compare_field("partition_begin", 32'(want.partition_begin), 32'(tdata[25:14]));
            compare_field("partition_end",   32'($unsigned(want.partition_end)),
                          32'(tdata[38:26]));
            compare_field("max_hit_range",   32'(want.max_hit_range),   32'(tdata[62:39]));
            compare_field("tdata_pad",       32'd0,                     32'(tdata[63]));
            compare_field("partition_found", 32'(want.partition_found), 32'(tuser));
            compare_field("final_result",    32'(want.final_result),    32'(tlast));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ray_decision_scoreboard sb = new();
    int                     burst_left = 0;
    int                     rays_sent = 0;
    int                     results_seen = 0;

    lidar_scan_segmenter #(
        .MAX_RAYS (LSS_MAX_RAYS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Check every decision the sink accepts against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
            results_seen++;
        end
    end

    // Result sink: switch between stall patterns at random points. Once, well into
    // the random traffic and while rays are on offer, hold off for a long stretch so the
    // result queue fills up and the block has to push back on ray requests.
    initial
    begin : result_sink
        int  mode;
        int  mode_left;
        bit  held;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 300 && s_tvalid)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Offer one ray request and hold it until accepted. The sender runs in bursts of
    // random length; between bursts valid either drops for a random gap or stays high.
    task automatic send_ray(input logic [RANGE_W-1:0] rng, input logic closing);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= rng;
        s_tlast  <= closing;
        do @(posedge clk); while (!s_tready);
        sb.note_ray(rng, closing);
        rays_sent++;
    endtask

    // Stop sending and wait until every predicted decision has come back, then let the
    // block settle so it is surely idle before registers change.
    task automatic wait_for_drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.decisions_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(input logic [RANGE_W-1:0] rmin, input logic [RANGE_W-1:0] rmax,
                                 input logic [DISC_W-1:0] disc, input logic [BF_W-1:0] bf,
                                 input logic [SIZE_W-1:0] msize, input logic en);
        write_reg(CFG_RANGE_MIN, rmin);
        write_reg(CFG_RANGE_MAX, rmax);
        write_reg(CFG_DISCOUNT, CFG_DATA_W'(disc));
        write_reg(CFG_BREAK_FAC, CFG_DATA_W'(bf));
        write_reg(CFG_MIN_SIZE, CFG_DATA_W'(msize));
        write_reg(CFG_PART_EN, CFG_DATA_W'(en));
        cfg_valid <= 1'b0;
    endtask

    // Pick a setting per register, with the extremes coming up often.
    task automatic load_random_settings();
        int                 pick;
        logic [RANGE_W-1:0] rmin;
        logic [RANGE_W-1:0] rmax;
        logic [DISC_W-1:0]  disc;
        logic [BF_W-1:0]    bf;
        logic [SIZE_W-1:0]  msize;
        logic               en;
        pick = $urandom_range(0, 9);
        if (pick < 4)       rmin = '0;
        else if (pick < 8)  rmin = RANGE_W'($urandom_range(1, 2000));
        else if (pick == 8) rmin = RANGE_W'($urandom);
        else                rmin = 24'd16777214;
        pick = $urandom_range(0, 9);
        if (pick < 5)       rmax = 24'd16777214;
        else if (pick == 5) rmax = NONFINITE;
        else if (pick < 8)  rmax = RANGE_W'($urandom_range(8000000, 16777214));
        else if (pick == 8) rmax = RANGE_W'($urandom);
        else                rmax = '0;
        pick = $urandom_range(0, 5);
        if (pick < 2)       disc = '0;
        else if (pick == 2) disc = 16'hFFFF;
        else if (pick == 3) disc = RST_DISCOUNT;
        else                disc = DISC_W'($urandom);
        pick = $urandom_range(0, 5);
        if (pick == 0)      bf = '0;
        else if (pick == 1) bf = 16'hFFFF;
        else if (pick == 2) bf = RST_BREAK_FAC;
        else                bf = BF_W'($urandom_range(128, 2048));
        pick = $urandom_range(0, 6);
        if (pick == 0)      msize = '0;
        else if (pick == 1) msize = 13'd1;
        else if (pick == 2) msize = 13'd4096;
        else                msize = SIZE_W'($urandom_range(1, 12));
        en = ($urandom_range(0, 5) != 0);
        load_settings(rmin, rmax, disc, bf, msize, en);
    endtask

    // One scan: mostly a smooth surface with random step spread, broken by jumps,
    // missing returns and non-finite codes. A noisy scan is fully random ranges.
    task automatic send_scan(input int len, input bit noisy);
        int                 base;
        int                 spread;
        int                 pick;
        int                 i;
        logic [RANGE_W-1:0] rng;
        base   = $urandom_range(1, 16777214);
        spread = 1 << $urandom_range(0, 12);
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (noisy)
                rng = RANGE_W'($urandom);
            else if (pick < 5)
                rng = '0;
            else if (pick < 9)
                rng = NONFINITE;
            else
            begin
                if (pick < 17)
                    base = $urandom_range(1, 16777214);
                else
                    base = base + int'($urandom_range(0, 2 * spread)) - spread;
                if (base < 1)
                    base = 1;
                if (base > 16777214)
                    base = 16777214;
                rng = RANGE_W'(base);
            end
            send_ray(rng, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int goal;
        int len;
        int pick;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: smooth run ended by a jump, non-finite then the largest range,
        // a missing return and a closing ray.
        send_ray(24'd1000, 1'b0);
        send_ray(24'd1010, 1'b0);
        send_ray(24'd1020, 1'b0);
        send_ray(24'd1030, 1'b0);
        send_ray(24'd1040, 1'b0);
        send_ray(24'd1050, 1'b0);
        send_ray(24'd900000, 1'b0);
        send_ray(NONFINITE, 1'b0);
        send_ray(24'd16777214, 1'b0);
        send_ray(24'd16777214, 1'b0);
        send_ray(24'd0, 1'b0);
        send_ray(24'd1, 1'b1);
        wait_for_drain();

        // Minimum size zero and a window reaching up to the non-finite code: a lone
        // missing ray emits a partition ending before ray 0.
        load_settings(24'd100, NONFINITE, 16'd0, 16'hFFFF, 13'd0, 1'b1);
        send_ray(24'd0, 1'b1);
        send_ray(24'd50, 1'b0);
        send_ray(NONFINITE, 1'b0);
        send_ray(24'd200, 1'b0);
        send_ray(24'd300, 1'b0);
        send_ray(24'd400, 1'b1);
        wait_for_drain();

        // Partitioning off: only hits and the running maximum move.
        load_settings(24'd0, 24'd16777214, 16'hFFFF, 16'd0, 13'd4096, 1'b0);
        send_ray(24'd5, 1'b0);
        send_ray(24'd70000, 1'b0);
        send_ray(24'd0, 1'b0);
        send_ray(NONFINITE, 1'b0);
        send_ray(24'h800000, 1'b1);
        wait_for_drain();

        // Random phases: new settings, a few scans, then drain before the next write.
        goal = rays_sent + 800;
        while (rays_sent < goal)
        begin
            load_random_settings();
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)       len = $urandom_range(1, 40);
                else if (pick == 8) len = $urandom_range(41, 200);
                else                len = 1;
                send_scan(len, $urandom_range(0, 7) == 0);
            end
            wait_for_drain();
        end
        repeat (16) @(posedge clk);

        if (sb.errors == 0 && sb.decisions_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #(8 * 1000000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
